### src/sdr_tx_iq_packet_framer_unit_defines.svh
// Assertion macros shared by the transmit IQ packet framer.
`ifndef SDR_TX_IQ_PACKET_FRAMER_UNIT_DEFINES_SVH
`define SDR_TX_IQ_PACKET_FRAMER_UNIT_DEFINES_SVH

// Checked on every rising edge while reset is released.
`define SDRTX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SDRTX_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/sdrtx_pkg.sv
// Constants and helper functions for the transmit IQ packet framer.
`default_nettype none

package sdrtx_pkg;

	localparam int unsigned SDRTX_ADDR_W = 3;
	localparam int unsigned SDRTX_DATA_W = 32;
	localparam int unsigned SDRTX_RATE_W = 19;
	localparam int unsigned SDRTX_CMD_W = 8;
	localparam int unsigned SDRTX_POS_W = 7;

	localparam logic [SDRTX_ADDR_W-1:0] REG_TX_RATE_HZ = 3'd0;
	localparam logic [SDRTX_ADDR_W-1:0] REG_COMMAND_BYTE = 3'd4;

	localparam logic [SDRTX_RATE_W-1:0] RATE_RESET = 19'd48000;
	localparam logic [SDRTX_CMD_W-1:0] CMD_RESET = 8'd1;

	localparam logic [SDRTX_POS_W-1:0] POS_FIRST = 7'd0;
	localparam logic [SDRTX_POS_W-1:0] POS_SECOND_HALF = 7'd63;
	localparam logic [SDRTX_POS_W-1:0] POS_LAST = 7'd125;

	localparam logic [31:0] HEADER_SYNC = 32'hEFFE0102;
	localparam logic [23:0] FRAME_SYNC = 24'h7F7F7F;
	localparam logic [7:0] FRAME_C4_FIRST = 8'h00;
	localparam logic [7:0] FRAME_C4_SECOND = 8'h04;

	// Index of the word emitted for an item, in emission order.
	localparam logic [1:0] IDX_FIRST = 2'd0;
	localparam logic [1:0] IDX_SECOND = 2'd1;
	localparam logic [1:0] IDX_THIRD = 2'd2;

	function automatic logic [1:0] rate_code(input logic [SDRTX_RATE_W-1:0] hz);
		logic [1:0] code;
		if (hz <= 19'd48000) begin
			code = 2'd0;
		end else if (hz <= 19'd96000) begin
			code = 2'd1;
		end else if (hz <= 19'd192000) begin
			code = 2'd2;
		end else begin
			code = 2'd3;
		end
		return code;
	endfunction

	// Scales by 32767 / 2^23, rounding half away from zero, optionally negating.
	// The product is built as mag * 2^15 - mag, so no multiplier is needed.
	function automatic logic [15:0] scale_sample(input logic [23:0] raw, input logic negate);
		logic neg;
		logic [23:0] mag;
		logic [38:0] prod;
		logic [15:0] m;
		neg = raw[23];
		mag = neg ? (24'd0 - raw) : raw;
		prod = ({mag, 15'd0} - {15'd0, mag}) + 39'h400000;
		m = prod[38:23];
		return (neg ^ negate) ? (16'd0 - m) : m;
	endfunction

endpackage

`default_nettype wire

### src/sdrtx_if.sv
// Valid/ready channel interfaces for IQ sample pairs and packet words.
`default_nettype none

interface sdrtx_iq_if;
	logic valid;
	logic ready;
	logic signed [23:0] i_sample;
	logic signed [23:0] q_sample;

	modport source (output valid, output i_sample, output q_sample, input ready);
	modport sink (input valid, input i_sample, input q_sample, output ready);
endinterface

interface sdrtx_word_if;
	logic valid;
	logic ready;
	logic [63:0] packet_word;
	logic last_word;

	modport source (output valid, output packet_word, output last_word, input ready);
	modport sink (input valid, input packet_word, input last_word, output ready);
endinterface

`default_nettype wire

### src/sdr_tx_iq_packet_framer_unit.sv
// Each request passes the input register s1, the emission stage s2 and the output register
// s3. A packet start yields header, frame and sample words; the midpoint, frame and sample.
// Throughput: one packet word per cycle while packets.ready holds. A request is taken every
// cycle unless the output stalls or a header or frame word is pending (126 requests, 129 words).
// Reset: arst_n clears all pipeline valids, the packet position and sequence count,
// and loads tx_rate_hz = 48000 and command_byte = 1.
`default_nettype none
`include "sdr_tx_iq_packet_framer_unit_defines.svh"

module sdr_tx_iq_packet_framer_unit
	import sdrtx_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	sdrtx_iq_if.sink samples,
	sdrtx_word_if.source packets,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [SDRTX_ADDR_W-1:0] paddr,
	input wire logic [SDRTX_DATA_W-1:0] pwdata,
	output logic [SDRTX_DATA_W-1:0] prdata,
	output logic pready
);

	logic [SDRTX_RATE_W-1:0] rate_q;
	logic [SDRTX_CMD_W-1:0] cmd_q;
	logic [SDRTX_POS_W-1:0] pos_q;
	logic [31:0] seq_q;

	logic s1_valid_s1;
	logic [23:0] i_s1;
	logic [23:0] q_s1;

	logic em_valid_s2;
	logic [SDRTX_POS_W-1:0] em_pos_s2;
	logic [1:0] em_idx_s2;
	logic [31:0] em_word_s2;

	logic pk_valid_s3;
	logic [63:0] pk_word_s3;
	logic pk_last_s3;

	logic out_free;
	logic emit;
	logic em_final;
	logic em_load;
	logic [63:0] em_out;
	logic [63:0] frame_base;
	logic cfg_wr;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_COMMAND_BYTE[2]) begin
			prdata = {{(SDRTX_DATA_W-SDRTX_CMD_W){1'b0}}, cmd_q};
		end else begin
			prdata = {{(SDRTX_DATA_W-SDRTX_RATE_W){1'b0}}, rate_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			cmd_q <= CMD_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_COMMAND_BYTE[2]) begin
				cmd_q <= pwdata[SDRTX_CMD_W-1:0];
			end else begin
				rate_q <= pwdata[SDRTX_RATE_W-1:0];
			end
		end
	end

	// Handshake between the three stages.
	assign out_free = !pk_valid_s3 || packets.ready;
	assign emit = em_valid_s2 && out_free;
	assign em_load = s1_valid_s1 && (!em_valid_s2 || (emit && em_final));
	assign samples.ready = !s1_valid_s1 || em_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			s1_valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			i_s1 <= samples.i_sample;
			q_s1 <= samples.q_sample;
		end
	end

	// Emission stage: one item may expand to a header, frame and sample word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_s2 <= 1'b0;
			em_pos_s2 <= POS_FIRST;
			em_idx_s2 <= IDX_FIRST;
			pos_q <= POS_FIRST;
			seq_q <= '0;
		end else if (em_load) begin
			em_valid_s2 <= 1'b1;
			em_pos_s2 <= pos_q;
			em_idx_s2 <= IDX_FIRST;
			pos_q <= (pos_q == POS_LAST) ? POS_FIRST : pos_q + 7'd1;
			// The header of a new packet carries the incremented count.
			if (pos_q == POS_FIRST) begin
				seq_q <= seq_q + 32'd1;
			end
		end else if (emit) begin
			if (em_final) begin
				em_valid_s2 <= 1'b0;
			end else begin
				em_idx_s2 <= em_idx_s2 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (em_load) begin
			em_word_s2 <= {scale_sample(i_s1, 1'b0), scale_sample(q_s1, 1'b1)};
		end
	end

	assign frame_base = {FRAME_SYNC, cmd_q, 6'd0, rate_code(rate_q), 16'd0, 8'd0};

	always_comb begin
		em_final = 1'b1;
		em_out = {32'd0, em_word_s2};
		priority if (em_pos_s2 == POS_FIRST && em_idx_s2 == IDX_FIRST) begin
			em_final = 1'b0;
			em_out = {HEADER_SYNC, seq_q};
		end else if (em_pos_s2 == POS_FIRST && em_idx_s2 == IDX_SECOND) begin
			em_final = 1'b0;
			em_out = frame_base | {56'd0, FRAME_C4_FIRST};
		end else if (em_pos_s2 == POS_SECOND_HALF && em_idx_s2 == IDX_FIRST) begin
			em_final = 1'b0;
			em_out = frame_base | {56'd0, FRAME_C4_SECOND};
		end else begin
			em_final = 1'b1;
			em_out = {32'd0, em_word_s2};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_valid_s3 <= 1'b0;
		end else if (out_free) begin
			pk_valid_s3 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pk_word_s3 <= em_out;
			pk_last_s3 <= em_final && (em_pos_s2 == POS_LAST);
		end
	end

	assign packets.valid = pk_valid_s3;
	assign packets.packet_word = pk_word_s3;
	assign packets.last_word = pk_last_s3;

	`SDRTX_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
	`SDRTX_ASSERT(a_pos_range, pos_q <= POS_LAST, "packet position beyond last sample")
	`SDRTX_ASSERT(a_idx_range,
		em_valid_s2 |-> (em_idx_s2 == IDX_FIRST)
			|| (em_idx_s2 == IDX_SECOND
				&& (em_pos_s2 == POS_FIRST || em_pos_s2 == POS_SECOND_HALF))
			|| (em_idx_s2 == IDX_THIRD && em_pos_s2 == POS_FIRST),
		"emission index past the words of its item")
	`SDRTX_ASSERT(a_last_is_sample,
		pk_valid_s3 && pk_last_s3 |-> pk_word_s3[63:32] == 32'd0,
		"last word is not a sample word")
	`SDRTX_ASSERT(a_seq_on_start,
		em_load && pos_q == POS_FIRST |=> seq_q == $past(seq_q) + 32'd1,
		"sequence count did not advance at packet start")

endmodule

`default_nettype wire
